FILE: sv/lds_pkg.sv
// ----------------------------------------------------------------------------
// lds_pkg
// Shared word types and fixed constants for the longest distinct run block.
// ----------------------------------------------------------------------------
`default_nettype none

package lds_pkg;

    // widths fixed by the interface
    localparam int CHAR_W    = 8;
    localparam int OUT_LEN_W = 16;

    // reported lengths saturate here
    localparam logic [OUT_LEN_W-1:0] LEN_MAX = {OUT_LEN_W{1'b1}};

    // input word: one byte of the string
    typedef struct packed {
        logic [CHAR_W-1:0] char_value;
        logic              start_new;
    } t_in_word;

    // output word: one result per byte
    typedef struct packed {
        logic [OUT_LEN_W-1:0] window_length;
        logic [OUT_LEN_W-1:0] best_length;
        logic                 length_overflow;
    } t_out_word;

endpackage

`default_nettype wire

FILE: sv/lds_ram.sv
// ----------------------------------------------------------------------------
// lds_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/longest_distinct_run.sv
// ----------------------------------------------------------------------------
// longest_distinct_run
// Streaming longest run of distinct symbols over a byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per clock and returns, for each byte, the length
// of the run of distinct symbols ending at that byte, the best such length in
// the current string and a sticky overflow flag. An accepted byte is held in
// the compute stage, then its result in the output register. Throughput is one
// word per cycle while neither side stalls, set by the single read-modify-write
// of the last-position RAM, whose registered read is covered by forwarding the
// position written at the same edge as the read. Seen flags live in flip-flops
// so that start_new clears them together; no clearing pass is needed after
// reset. Either side may stall at any time; ready falls only when both the
// compute stage and output register hold words and the output is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_distinct_run
    import lds_pkg::*;
#(
    parameter int ALPHABET_BITS = 8,
    parameter int POS_BITS      = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    localparam int SYM_COUNT = 1 << ALPHABET_BITS;
    localparam int LW = (POS_BITS + 1 > OUT_LEN_W + 1) ? POS_BITS + 1 : OUT_LEN_W + 1;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // symbol index from the incoming byte
    logic [ALPHABET_BITS-1:0] in_sym;
    generate
        if (ALPHABET_BITS <= CHAR_W) begin : g_sym_narrow
            assign in_sym = i_in_word.char_value[ALPHABET_BITS-1:0];
        end else begin : g_sym_wide
            assign in_sym = {{(ALPHABET_BITS - CHAR_W){1'b0}}, i_in_word.char_value};
        end
    endgenerate

    // stage and output registers
    logic                     r_s1_valid;
    logic [ALPHABET_BITS-1:0] r_s1_sym;
    logic                     r_s1_start;
    logic                     r_s1_fwd;
    logic [POS_BITS-1:0]      r_s1_fwd_idx;
    logic                     r_out_valid;
    t_out_word                r_out_word;

    // per-string state
    logic [SYM_COUNT-1:0]     r_seen;
    logic [POS_BITS-1:0]      r_pos;
    logic [POS_BITS-1:0]      r_ws;
    logic [OUT_LEN_W-1:0]     r_best;
    logic                     r_ovf;

    logic                     out_free;
    logic                     s1_done;
    logic                     in_accept;
    logic [POS_BITS-1:0]      ram_rdata;

    // handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_done    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    // compute stage
    logic [POS_BITS-1:0]  s1_idx;
    logic                 pos_sat;
    logic [POS_BITS-1:0]  n_pos;
    logic [POS_BITS-1:0]  last_pos;
    logic                 seen_hit;
    logic [POS_BITS:0]    after;
    logic [POS_BITS-1:0]  ws_base;
    logic [POS_BITS:0]    ws_moved;
    logic [POS_BITS-1:0]  n_ws;
    logic [LW-1:0]        len_full;
    logic                 len_sat;
    logic [OUT_LEN_W-1:0] len_out;
    logic [OUT_LEN_W-1:0] best_base;
    logic [OUT_LEN_W-1:0] n_best;
    logic                 n_ovf;
    logic [SYM_COUNT-1:0] n_seen;

    always_comb begin
        s1_idx   = r_s1_start ? '0 : r_pos;
        pos_sat  = !r_s1_start && (r_pos == POS_MAX);
        n_pos    = pos_sat ? POS_MAX : s1_idx + POS_BITS'(1);

        // last position, forwarded when written at the read edge
        last_pos = r_s1_fwd ? r_s1_fwd_idx : ram_rdata;
        seen_hit = !r_s1_start && r_seen[r_s1_sym];
        after    = {1'b0, last_pos} + (POS_BITS + 1)'(1);

        // move window start past the previous occurrence, clamp to index
        ws_base  = r_s1_start ? '0 : r_ws;
        ws_moved = (seen_hit && (after > {1'b0, ws_base})) ? after : {1'b0, ws_base};
        n_ws     = (ws_moved > {1'b0, s1_idx}) ? s1_idx : ws_moved[POS_BITS-1:0];

        // window length with saturation
        len_full = LW'(s1_idx) - LW'(n_ws) + LW'(1);
        len_sat  = len_full > LW'(LEN_MAX);
        len_out  = len_sat ? LEN_MAX : len_full[OUT_LEN_W-1:0];

        best_base = r_s1_start ? '0 : r_best;
        n_best    = (len_out > best_base) ? len_out : best_base;
        n_ovf     = (!r_s1_start && r_ovf) || pos_sat || len_sat;

        // seen flags, cleared by a new string, then marked for this symbol
        n_seen    = (r_s1_start ? '0 : r_seen) | (SYM_COUNT'(1) << r_s1_sym);
    end

    // last-position memory
    lds_ram #(
        .WIDTH (POS_BITS),
        .DEPTH (SYM_COUNT)
    ) u_last_seen (
        .i_clk   (i_clk),
        .i_we    (s1_done),
        .i_waddr (r_s1_sym),
        .i_wdata (s1_idx),
        .i_re    (in_accept),
        .i_raddr (in_sym),
        .o_rdata (ram_rdata)
    );

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage payload and forwarding decision
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sym     <= in_sym;
            r_s1_start   <= i_in_word.start_new;
            r_s1_fwd     <= s1_done && (r_s1_sym == in_sym);
            r_s1_fwd_idx <= s1_idx;
        end
    end

    // per-string state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_pos  <= '0;
            r_ws   <= '0;
            r_best <= '0;
            r_ovf  <= 1'b0;
        end else if (s1_done) begin
            r_seen <= n_seen;
            r_pos  <= n_pos;
            r_ws   <= n_ws;
            r_best <= n_best;
            r_ovf  <= n_ovf;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_out_word.window_length   <= len_out;
            r_out_word.best_length     <= n_best;
            r_out_word.length_overflow <= n_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // the best length never falls below the current window
    a_best_covers_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.window_length <= r_out_word.best_length))
        else $error("best length below window length");

    // a window always holds at least the current byte
    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.window_length != '0))
        else $error("empty window reported");

    // a new string starts with a window of one
    a_restart_len_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && r_s1_start) |=> (r_out_word.window_length == OUT_LEN_W'(1)))
        else $error("restart did not give window of one");

    // overflow stays set within a string
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && !r_s1_start && r_ovf) |=> r_out_word.length_overflow)
        else $error("overflow flag dropped within string");

    // input stalls only when both stage and output are full
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room downstream");

endmodule

`default_nettype wire

FILE: bench/longest_distinct_run_test.sv
// ----------------------------------------------------------------------------
// longest_distinct_run_test
// Self-checking bench for the streaming longest distinct run block.
// ----------------------------------------------------------------------------
// Bytes are fed over the valid/ready input channel, and every result word is
// checked against a predictor kept in a small scoreboard class. Stimulus runs
// in this order: a short hand-written script, one full-alphabet distinct run,
// a run of one repeated symbol, then random strings mixed with stray restarts
// and unbroken continuations. Random source idling and sink stalls vary from
// phase to phase.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_distinct_run_test
    import lds_pkg::*;
();

    localparam int SYM_BITS = 8;
    localparam int POS_W    = 16;
    localparam int SYM_NUM  = 1 << SYM_BITS;
    localparam longint unsigned POS_TOP = (64'd1 << POS_W) - 64'd1;
    localparam longint unsigned LEN_TOP = longint'(LEN_MAX);
    localparam int RANDOM_PER_PHASE = 60;
    localparam int LIMIT_CYCLES     = 1_000_000;
    localparam int SETTLE_CYCLES    = 16;

    // predicts run lengths for each accepted byte and checks result words
    class distinct_run_tracker;
        bit [POS_W-1:0]     last_index [0:SYM_NUM-1];
        bit [SYM_NUM-1:0]   seen_mask;
        longint unsigned    next_index;
        longint unsigned    run_start;
        longint unsigned    best_so_far;
        bit                 saturated;
        t_out_word          pending_runs [$];
        int                 mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            seen_mask   = '0;
            next_index  = 0;
            run_start   = 0;
            best_so_far = 0;
            saturated   = 1'b0;
        endfunction

        function void note_byte(t_in_word w);
            int unsigned     sym;
            longint unsigned idx;
            longint unsigned after;
            longint unsigned len;
            t_out_word       r;
            sym = int'(w.char_value) & (SYM_NUM - 1);
            if (w.start_new) begin
                restart();
            end
            // position counter sticks at its top value
            idx = next_index;
            if (next_index >= POS_TOP) begin
                next_index = POS_TOP;
                idx        = POS_TOP;
                saturated  = 1'b1;
            end else begin
                next_index = next_index + 1;
            end
            // slide the window past the previous occurrence
            if (seen_mask[sym]) begin
                after = longint'(last_index[sym]) + 1;
                if (after > run_start) begin
                    run_start = after;
                end
            end
            if (run_start > idx) begin
                run_start = idx;
            end
            last_index[sym] = idx[POS_W-1:0];
            seen_mask[sym]  = 1'b1;
            len = idx - run_start + 1;
            if (len > LEN_TOP) begin
                len       = LEN_TOP;
                saturated = 1'b1;
            end
            if (len > best_so_far) begin
                best_so_far = len;
            end
            r.window_length   = len[OUT_LEN_W-1:0];
            r.best_length     = best_so_far[OUT_LEN_W-1:0];
            r.length_overflow = saturated;
            pending_runs.push_back(r);
        endfunction

        function void check_run(t_out_word got);
            t_out_word want;
            if (pending_runs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: window %0d best %0d overflow %0b",
                             got.window_length, got.best_length, got.length_overflow);
                end
                return;
            end
            want = pending_runs.pop_front();
            if (got.window_length !== want.window_length
                    || got.best_length !== want.best_length
                    || got.length_overflow !== want.length_overflow) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp/act: window %0d/%0d best %0d/%0d ovf %0b/%0b",
                             want.window_length, got.window_length,
                             want.best_length, got.best_length,
                             want.length_overflow, got.length_overflow);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    distinct_run_tracker tracker;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int random_sent  = 0;

    longest_distinct_run #(
        .ALPHABET_BITS(SYM_BITS),
        .POS_BITS     (POS_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // sink side stalls at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // note accepted bytes first, then check the result word taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            tracker.note_byte(i_in_word);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_run(o_out_word);
        end
    end

    // watchdog
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // one byte over the input channel, with an optional idle gap in front
    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic fresh);
        t_in_word w;
        w.char_value = ch;
        w.start_new  = fresh;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // random bytes drawn from a window of span symbols
    task automatic send_string(input int len, input int span, input logic fresh);
        int base;
        base = $urandom_range(0, SYM_NUM - span);
        for (int i = 0; i < len; i++) begin
            send_byte(CHAR_W'(base + $urandom_range(0, span - 1)), fresh && (i == 0));
            random_sent++;
        end
    endtask

    // random strings: mostly well formed, some stray restarts and continuations
    task automatic send_random_mix(input int quota);
        int spans [6] = '{1, 2, 4, 16, 64, 256};
        int kind;
        int len;
        int base;
        while (random_sent < quota) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 40);
            if (kind <= 6) begin
                send_string(len, spans[$urandom_range(0, 5)], 1'b1);
            end else if (kind == 7) begin
                // ascending distinct run that wraps round the alphabet
                base = $urandom_range(0, SYM_NUM - 1);
                len  = $urandom_range(20, 60);
                for (int i = 0; i < len; i++) begin
                    send_byte(CHAR_W'(base + i), i == 0);
                    random_sent++;
                end
            end else if (kind == 8) begin
                send_byte(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                random_sent++;
            end else begin
                send_string(len, spans[$urandom_range(0, 5)], 1'b0);
            end
        end
    endtask

    initial begin
        logic [CHAR_W-1:0] script_chars [22];
        logic              script_fresh [22];
        script_chars = '{
            8'h00, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hFF, 8'hFF, 8'h00,
            8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h62, 8'h62,
            8'h55, 8'hAA, 8'h55, 8'hAA, 8'h7F, 8'hFE
        };
        script_fresh = '{
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
        };
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 0: no idling on either side
        idle_pct  = 0;
        stall_pct = 0;
        // short script: first byte without restart, repeats, back to back restarts
        for (int i = 0; i < 22; i++) begin
            send_byte(script_chars[i], script_fresh[i]);
        end
        // every symbol once, then repeats at both ends of the alphabet
        for (int i = 0; i < SYM_NUM; i++) begin
            send_byte(CHAR_W'(i), i == 0);
        end
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // one symbol over and over brings the window back to one after its first byte
        repeat (6) send_byte(8'h42, 1'b0);
        send_random_mix(RANDOM_PER_PHASE);

        // phase 1: source mostly idle
        idle_pct  = 79;
        stall_pct = 0;
        send_random_mix(2 * RANDOM_PER_PHASE);

        // phase 2: sink mostly stalled
        idle_pct  = 0;
        stall_pct = 79;
        send_random_mix(3 * RANDOM_PER_PHASE);

        // phase 3: both sides idle now and then
        idle_pct  = 25;
        stall_pct = 25;
        send_random_mix(4 * RANDOM_PER_PHASE);
        i_in_valid <= 1'b0;

        // drain outstanding results, then allow a few spare cycles
        while (tracker.pending_runs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_runs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/lds_pkg.sv
sv/lds_ram.sv
sv/longest_distinct_run.sv
bench/longest_distinct_run_test.sv
